FILE: src/hlfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hlfr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam int LENGTH_LIMIT_DEF = 50;

  localparam logic [BYTE_W-1:0] FIRST_HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hAF;
  localparam logic [CFG_DATA_W-1:0] FUNCTION_LIMIT_RST = 9'h0F1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_LIMIT = 2'd2;

  typedef enum logic [7:0] {
    ST_HUNT        = 8'b0000_0001,
    ST_SECOND      = 8'b0000_0010,
    ST_FUNC        = 8'b0000_0100,
    ST_LEN         = 8'b0000_1000,
    ST_PAYLOAD     = 8'b0001_0000,
    ST_CHECK       = 8'b0010_0000,
    ST_REPLAY_RD   = 8'b0100_0000,
    ST_REPLAY_WAIT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic store;
    logic store_first;
    logic load_len;
    logic dec_rem;
    logic rd_start;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic func_ok;
    logic len_ok;
    logic rem_zero;
    logic rem_one;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: src/header_length_frame_receiver.sv
// Framed byte receiver with a two-byte header and a length byte.
// The input channel (in_valid, in_ready, in_rx_byte) takes one received byte
// per word. The block hunts for the two header bytes, a function byte below
// the configured limit, a length byte below LENGTH_LIMIT, the payload bytes
// and a trailing check byte, storing each one in a frame store memory.
// Any byte that breaks the frame is dropped and hunting starts again.
// While receiving, in_ready stays high.
// After the check byte the stored frame is replayed on the output channel
// (out_valid, out_ready, out_frame_byte, out_frame_last), header first, with
// out_frame_last set on the check byte. Each word is read from the
// registered read port of the frame store in ST_REPLAY_RD and loaded into
// the output register in ST_REPLAY_WAIT before the next word is read.
// in_ready is low during the replay.
// When the receiver stalls, the output register holds its word and the
// replay waits; the next byte is taken while the last word still waits.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) sets the two
// header values and the function limit, and should be written only when idle.
// Synchronous reset restores the default header values and limit and
// returns the block to hunting with the output channel empty.
`timescale 1ns / 1ps
`default_nettype none
module header_length_frame_receiver
  import hlfr_pkg::*;
#(
  parameter int LENGTH_LIMIT = LENGTH_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [BYTE_W-1:0]     out_frame_byte,
  output logic                       out_frame_last
);

  cmd_t    cmd;
  status_t status;

  hlfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hlfr_dp #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rx_byte     (in_rx_byte),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
`default_nettype wire

FILE: src/hlfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 54
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: src/hlfr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hlfr_ctrl
  import hlfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   rx_state;
  logic   fire;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    rx_state = 1'b0;
    fire = 1'b0;
    case (state_r)
      ST_HUNT: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire && status.is_first) begin
          cmd.store = 1'b1;
          cmd.store_first = 1'b1;
          state_nxt = ST_SECOND;
        end
      end
      ST_SECOND: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire) begin
          if (status.is_second) begin
            cmd.store = 1'b1;
            state_nxt = ST_FUNC;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_FUNC: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire) begin
          if (status.func_ok) begin
            cmd.store = 1'b1;
            state_nxt = ST_LEN;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_LEN: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire) begin
          if (status.len_ok) begin
            cmd.store = 1'b1;
            cmd.load_len = 1'b1;
            state_nxt = ST_PAYLOAD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_PAYLOAD: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire) begin
          if (status.rem_zero) begin
            state_nxt = ST_HUNT;
          end else begin
            cmd.store = 1'b1;
            cmd.dec_rem = 1'b1;
            if (status.rem_one) begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        rx_state = 1'b1;
        fire = in_valid;
        if (fire) begin
          cmd.store = 1'b1;
          cmd.rd_start = 1'b1;
          state_nxt = ST_REPLAY_RD;
        end
      end
      ST_REPLAY_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt = ST_REPLAY_WAIT;
      end
      ST_REPLAY_WAIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = status.rd_last ? ST_HUNT : ST_REPLAY_RD;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  assign in_ready = rx_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/hlfr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hlfr_dp
  import hlfr_pkg::*;
#(
  parameter int LENGTH_LIMIT = LENGTH_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic      [BYTE_W-1:0]     out_frame_byte,
  output logic                       out_frame_last,
  input  wire cmd_t                  cmd,
  output status_t                    status
);

  localparam int DEPTH = LENGTH_LIMIT + 4;
  localparam int AW = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int CNT_W = $clog2(LENGTH_LIMIT);

  logic [BYTE_W-1:0]     first_header_r, first_header_nxt;
  logic [BYTE_W-1:0]     second_header_r, second_header_nxt;
  logic [CFG_DATA_W-1:0] function_limit_r, function_limit_nxt;
  logic [CNT_W-1:0]      bytes_rem_r, bytes_rem_nxt;
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_last_r;
  logic [AW-1:0]         wr_addr;
  logic [BYTE_W-1:0]     ram_rdata;

  always_comb begin
    first_header_nxt = first_header_r;
    second_header_nxt = second_header_r;
    function_limit_nxt = function_limit_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIRST_HEADER:   first_header_nxt = cfg_wdata[BYTE_W-1:0];
        CFG_SECOND_HEADER:  second_header_nxt = cfg_wdata[BYTE_W-1:0];
        CFG_FUNCTION_LIMIT: function_limit_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign wr_addr = cmd.store_first ? '0 : wr_ptr_r[AW-1:0];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (cmd.store) begin
      wr_ptr_nxt = PTR_W'(wr_addr) + PTR_W'(1);
    end
    bytes_rem_nxt = bytes_rem_r;
    if (cmd.load_len) begin
      bytes_rem_nxt = in_rx_byte[CNT_W-1:0];
    end else if (cmd.dec_rem) begin
      bytes_rem_nxt = bytes_rem_r - CNT_W'(1);
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.out_load && !status.rd_last) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    status.is_first = (in_rx_byte == first_header_r);
    status.is_second = (in_rx_byte == second_header_r);
    status.func_ok = ({1'b0, in_rx_byte} < function_limit_r);
    status.len_ok = ({1'b0, in_rx_byte} < 9'(LENGTH_LIMIT));
    status.rem_zero = (bytes_rem_r == '0);
    status.rem_one = (bytes_rem_r == CNT_W'(1));
    status.rd_last = ((PTR_W'(rd_idx_r) + PTR_W'(1)) == wr_ptr_r);
    status.out_free = !out_valid_r || out_ready;
  end

  hlfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_header_r <= FIRST_HEADER_RST;
      second_header_r <= SECOND_HEADER_RST;
      function_limit_r <= FUNCTION_LIMIT_RST;
      bytes_rem_r <= '0;
      wr_ptr_r <= '0;
      rd_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      first_header_r <= first_header_nxt;
      second_header_r <= second_header_nxt;
      function_limit_r <= function_limit_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_idx_r <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= ram_rdata;
      out_last_r <= status.rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;

endmodule
`default_nettype wire

FILE: src/hlfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module hlfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_frame_last))
    else $error("output word changed while stalled");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output word withdrawn without being taken");

  a_no_rx_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> !in_ready)
    else $error("input taken in the middle of a frame replay");

  a_replay_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result word appeared right after an input word");

endmodule

bind header_length_frame_receiver hlfr_checker u_hlfr_checker (.*);
`default_nettype wire

FILE: tb/tb_header_length_frame_receiver.sv
`timescale 1ns / 1ps
module tb_header_length_frame_receiver;
  import hlfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 12;

  typedef enum int {HUNT, SECOND_HDR, FUNC, LEN, PAYLOAD, CHECK} rx_phase_t;
  typedef enum int {CLEAN, BAD_SECOND, BAD_FUNC, BAD_LEN, CUT_SHORT} frame_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_word_t;

  class frame_replay_board;
    logic [BYTE_W-1:0]     first_hdr;
    logic [BYTE_W-1:0]     second_hdr;
    logic [CFG_DATA_W-1:0] func_limit;
    rx_phase_t             phase;
    int unsigned           remaining;
    int unsigned           stored_payload;
    logic [BYTE_W-1:0]     frame_mem [LENGTH_LIMIT_DEF + 4];
    frame_word_t           replay_q [$];
    int                    failures;
    int                    frames;
    int                    words_checked;
    int                    bytes_in;

    function new();
      first_hdr = FIRST_HEADER_RST;
      second_hdr = SECOND_HEADER_RST;
      func_limit = FUNCTION_LIMIT_RST;
      phase = HUNT;
      remaining = 0;
      stored_payload = 0;
      failures = 0;
      frames = 0;
      words_checked = 0;
      bytes_in = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FIRST_HEADER: first_hdr = val[BYTE_W-1:0];
        CFG_SECOND_HEADER: second_hdr = val[BYTE_W-1:0];
        CFG_FUNCTION_LIMIT: func_limit = val;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      int unsigned total;
      bytes_in++;
      if (phase == HUNT && b == first_hdr) begin
        frame_mem[0] = b;
        phase = SECOND_HDR;
      end else if (phase == SECOND_HDR && b == second_hdr) begin
        frame_mem[1] = b;
        phase = FUNC;
      end else if (phase == FUNC && {1'b0, b} < func_limit) begin
        frame_mem[2] = b;
        phase = LEN;
      end else if (phase == LEN && b < LENGTH_LIMIT_DEF) begin
        frame_mem[3] = b;
        remaining = b;
        stored_payload = 0;
        phase = PAYLOAD;
      end else if (phase == PAYLOAD && remaining > 0) begin
        remaining--;
        frame_mem[4 + stored_payload] = b;
        stored_payload++;
        if (remaining == 0) begin
          phase = CHECK;
        end
      end else if (phase == CHECK) begin
        frame_mem[4 + stored_payload] = b;
        total = stored_payload + 5;
        for (int k = 0; k < total; k++) begin
          replay_q.push_back('{data: frame_mem[k], last: (k + 1 == total)});
        end
        frames++;
        phase = HUNT;
      end else begin
        phase = HUNT;
      end
    endfunction

    function void check_word(logic [BYTE_W-1:0] data, logic last);
      frame_word_t want;
      words_checked++;
      if (replay_q.size() == 0) begin
        $display("%0t: unexpected frame word, expected none, got byte %02h last %0b",
                 $time, data, last);
        failures++;
        return;
      end
      want = replay_q.pop_front();
      if (data !== want.data) begin
        $display("%0t: frame_byte mismatch, expected %02h, got %02h", $time, want.data, data);
        failures++;
      end
      if (last !== want.last) begin
        $display("%0t: frame_last mismatch, expected %0b, got %0b", $time, want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return replay_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_frame_byte;
  logic                  out_frame_last;

  frame_replay_board sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  header_length_frame_receiver dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.take_byte(in_rx_byte);
      end
      if (out_valid && out_ready) begin
        sb.check_word(out_frame_byte, out_frame_last);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                          input logic [CFG_DATA_W-1:0] lim);
    cfg_write(CFG_FIRST_HEADER, {1'b0, h1});
    cfg_write(CFG_SECOND_HEADER, {1'b0, h2});
    cfg_write(CFG_FUNCTION_LIMIT, lim);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [BYTE_W-1:0] v;
    int n;
    send_byte(sb.first_hdr);
    if (kind == BAD_SECOND) begin
      do v = 8'($urandom_range(255)); while (v == sb.second_hdr);
      send_byte(v);
      return;
    end
    send_byte(sb.second_hdr);
    if (kind == BAD_FUNC && sb.func_limit <= 255) begin
      send_byte(8'($urandom_range(255, sb.func_limit)));
      return;
    end
    send_byte(8'($urandom_range(sb.func_limit >= 256 ? 255 : sb.func_limit - 1)));
    if (kind == BAD_LEN) begin
      send_byte(8'($urandom_range(255, LENGTH_LIMIT_DEF)));
      return;
    end
    send_byte(8'(len));
    n = (kind == CUT_SHORT) ? $urandom_range(len) : len + 1;
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int r;
    int len;
    int start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Shortest frame with the highest function byte the default limit allows.
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    send_byte(8'hF0);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    // A first header byte in place of the second is dropped, not restarted on.
    send_byte(sb.first_hdr);
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    // Function byte equal to the limit, then length equal to its limit.
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    send_byte(8'hF1);
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    send_byte(8'h00);
    send_byte(8'(LENGTH_LIMIT_DEF));
    // A zero length aborts the frame on the following byte.
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h55);
    drain();

    cfg_write(CFG_UNUSED, 9'h1FF);
    cfg_wr_en <= 1'b0;
    send_frame(CLEAN, 2);
    drain();
    set_regs(FIRST_HEADER_RST, SECOND_HEADER_RST, 9'd0);
    send_frame(BAD_FUNC, 0);
    send_byte(sb.first_hdr);
    send_byte(sb.second_hdr);
    send_byte(8'h00);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_regs(8'hFF, 8'h00, 9'd1);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_regs(8'h00, 8'hFF, 9'd256);
          idle_pct = 74;
          stall_pct = 0;
        end
        2: begin
          set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 9'h1FF);
          idle_pct = 0;
          stall_pct = 74;
        end
        default: begin
          set_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                   9'($urandom_range(255, 2)));
          idle_pct = 11;
          stall_pct = 11;
        end
      endcase
      if (p == 1) begin
        send_frame(CLEAN, LENGTH_LIMIT_DEF - 1);
      end
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        len = (r < 85) ? $urandom_range(8) :
              (r < 95) ? $urandom_range(LENGTH_LIMIT_DEF - 2, 9) : LENGTH_LIMIT_DEF - 1;
        r = $urandom_range(99);
        if (r < 75) begin
          send_frame(CLEAN, len);
        end else if (r < 80) begin
          send_frame(BAD_SECOND, len);
        end else if (r < 85) begin
          send_frame(BAD_FUNC, len);
        end else if (r < 90) begin
          send_frame(BAD_LEN, len);
        end else if (r < 95) begin
          send_frame(CUT_SHORT, len);
        end else begin
          repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
        end
      end
      drain();
    end

    $display("Run covered %0d received words and %0d replayed frames (%0d result words),",
             sb.bytes_in, sb.frames, sb.words_checked);
    $display("over six header and limit settings and sender and receiver idling up to 74%%.");
    if (sb.failures == 0) begin
      $display("header_length_frame_receiver regression: pass");
    end else begin
      $display("header_length_frame_receiver regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d frame words still awaited.", sb.pending());
    $display("header_length_frame_receiver regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/hlfr_pkg.sv
src/hlfr_ram.sv
src/hlfr_ctrl.sv
src/hlfr_dp.sv
src/header_length_frame_receiver.sv
src/hlfr_checker.sv
tb/tb_header_length_frame_receiver.sv
